// File: rtl/core/eirc_pkg.sv
`default_nettype none

package eirc_pkg;

    // Widths of the stream fields.
    localparam int SAMPLE_W = 32;
    localparam int COLOR_W  = 8;

    // Fixed-point and color constants.
    localparam int ONE_Q16    = 65536;
    localparam int COLOR_SPAN = 254;
    localparam int COLOR_TOP  = 255;
    localparam int COLOR_NONE = 0;
    localparam int COLOR_LOW  = 1;

    // Width of the magnitude handled by the shared divider.
    localparam int DIV_W = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_B    = 3'd5;
    localparam int CFG_DATA_W = 32;
    localparam int NCLS_W     = 5;

    // Interval held by one classifier cell.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] brk_lo;
        logic signed [SAMPLE_W-1:0] brk_hi;
        logic [COLOR_W-1:0]         color;
        logic                       en;
    } t_cell_cfg;

    // Sample traveling down the cell chain with its decision so far.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       found;
        logic [COLOR_W-1:0]         color;
    } t_tok;

endpackage

`default_nettype wire

// File: rtl/core/eirc_div.sv
`default_nettype none

module eirc_div #(
    parameter int DW = 5
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [eirc_pkg::DIV_W-1:0] i_dividend,
    input  wire  [DW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [eirc_pkg::DIV_W-1:0] o_quot,
    output logic [DW-1:0]              o_rem
);

    localparam int CW = $clog2(eirc_pkg::DIV_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [eirc_pkg::DIV_W-1:0] r_quot;
    logic [DW-1:0]              r_rem;
    logic [DW-1:0]              r_dvs;
    logic [DW:0]                w_trial;
    logic [DW:0]                w_diff;
    logic                       w_ge;
    logic [DW-1:0]              n_rem;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        w_trial = {r_rem, r_quot[eirc_pkg::DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    // Step control; a new start aborts any division in progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(eirc_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient shifts in as the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[eirc_pkg::DIV_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/core/eirc_setup.sv
`default_nettype none

module eirc_setup #(
    parameter int MAX_CLASSES = 16
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_restart,
    input  wire  signed [eirc_pkg::SAMPLE_W-1:0]     i_lo,
    input  wire  signed [eirc_pkg::SAMPLE_W-1:0]     i_hi,
    input  wire  [$clog2(MAX_CLASSES+1)-1:0]         i_n,
    input  wire                                      i_center,
    output eirc_pkg::t_cell_cfg                      o_cfg,
    output logic                                     o_shift,
    output logic                                     o_ready
);

    localparam int NW = $clog2(MAX_CLASSES + 1);
    localparam int AW = eirc_pkg::SAMPLE_W + 2;
    localparam logic [NW-1:0] T_LAST = NW'(MAX_CLASSES);

    localparam logic [2:0] S_START = 3'd0;
    localparam logic [2:0] S_DIV1  = 3'd1;
    localparam logic [2:0] S_DIV2  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_READY = 3'd4;

    logic [2:0]                       r_state;
    logic [NW-1:0]                    r_t;
    logic [AW-1:0]                    r_q1;
    logic [NW-1:0]                    r_r1;
    logic [eirc_pkg::COLOR_W-1:0]     r_q2;
    logic [NW-1:0]                    r_r2;
    logic [AW-1:0]                    r_qacc;
    logic [NW-1:0]                    r_racc;
    logic [eirc_pkg::COLOR_W-1:0]     r_cq;
    logic [NW-1:0]                    r_cr;
    logic [eirc_pkg::SAMPLE_W-1:0]    r_prev;

    logic [eirc_pkg::SAMPLE_W:0]      w_range;
    logic [eirc_pkg::SAMPLE_W:0]      w_mag;
    logic                             w_neg;
    logic                             w_start;
    logic [eirc_pkg::DIV_W-1:0]       w_dividend;
    logic [NW-1:0]                    w_divisor;
    logic                             w_done;
    logic [eirc_pkg::DIV_W-1:0]       w_qa;
    logic [NW-1:0]                    w_ra;
    logic                             w_rnz;
    logic [AW-1:0]                    w_q_ext;
    logic [NW-1:0]                    w_nm1;
    logic [NW:0]                      w_rsum;
    logic                             w_rc;
    logic [AW-1:0]                    w_qnext;
    logic [NW-1:0]                    w_rnext;
    logic [NW:0]                      w_csum;
    logic                             w_cc;
    logic [NW-1:0]                    w_cnext;
    logic [AW-1:0]                    w_brk_sum;
    logic [eirc_pkg::SAMPLE_W-1:0]    w_brk;

    // Span of the adjusted range and its magnitude for the divider.
    always_comb begin
        w_range = {i_hi[eirc_pkg::SAMPLE_W-1], i_hi} - {i_lo[eirc_pkg::SAMPLE_W-1], i_lo};
        w_neg   = w_range[eirc_pkg::SAMPLE_W];
        w_mag   = w_neg ? (~w_range + 1'b1) : w_range;
        w_nm1   = i_n - NW'(1);
    end

    // The divider first gives range/n, then 254/(n-1).
    always_comb begin
        w_start    = 1'b0;
        w_dividend = w_mag[eirc_pkg::DIV_W-1:0];
        w_divisor  = i_n;
        if (r_state == S_START) begin
            w_start = 1'b1;
        end else if (r_state == S_DIV1 && w_done) begin
            w_start    = 1'b1;
            w_dividend = eirc_pkg::DIV_W'(eirc_pkg::COLOR_SPAN);
            w_divisor  = w_nm1;
        end
    end

    eirc_div #(
        .DW(NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_quot     (w_qa),
        .o_rem      (w_ra)
    );

    // Floor quotient and nonnegative remainder of a signed span.
    always_comb begin
        w_rnz   = |w_ra;
        w_q_ext = {{(AW-eirc_pkg::DIV_W){1'b0}}, w_qa};
    end

    // Next break: accumulate quotient and remainder, carrying when the remainder wraps.
    always_comb begin
        w_rsum    = {1'b0, r_racc} + {1'b0, r_r1};
        w_rc      = (w_rsum >= {1'b0, i_n});
        w_rnext   = w_rc ? NW'(w_rsum - {1'b0, i_n}) : w_rsum[NW-1:0];
        w_qnext   = r_qacc + r_q1 + {{(AW-1){1'b0}}, w_rc};
        w_brk_sum = {{2{i_lo[eirc_pkg::SAMPLE_W-1]}}, i_lo} + w_qnext;
        w_brk     = w_brk_sum[eirc_pkg::SAMPLE_W-1:0];
        if (r_t == i_n) begin
            w_brk = i_hi;
        end else if (i_center && !i_n[0] && r_t == (i_n >> 1)) begin
            w_brk = '0;
        end
    end

    // Next class color offset: the same carry scheme over 254/(n-1).
    always_comb begin
        w_csum  = {1'b0, r_cr} + {1'b0, r_r2};
        w_cc    = (w_csum >= {1'b0, w_nm1});
        w_cnext = w_cc ? NW'(w_csum - {1'b0, w_nm1}) : w_csum[NW-1:0];
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_START;
        end else if (i_restart) begin
            r_state <= S_START;
        end else begin
            unique case (r_state)
                S_START: begin
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (w_done) r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (w_done) r_state <= S_FILL;
                end
                S_FILL: begin
                    if (r_t == T_LAST) r_state <= S_READY;
                end
                S_READY: begin
                    r_state <= S_READY;
                end
                default: begin
                    r_state <= S_START;
                end
            endcase
        end
    end

    // Quotients, accumulators and the break counter.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV1 && w_done) begin
            r_q1 <= w_neg ? (~w_q_ext + 1'b1 - {{(AW-1){1'b0}}, w_rnz}) : w_q_ext;
            r_r1 <= (w_neg && w_rnz) ? (i_n - w_ra) : w_ra;
        end
        if (r_state == S_DIV2 && w_done) begin
            r_q2   <= w_qa[eirc_pkg::COLOR_W-1:0];
            r_r2   <= w_ra;
            r_qacc <= '0;
            r_racc <= '0;
            r_cq   <= '0;
            r_cr   <= '0;
            r_t    <= NW'(1);
            r_prev <= i_lo;
        end else if (r_state == S_FILL) begin
            r_qacc <= w_qnext;
            r_racc <= w_rnext;
            r_cq   <= r_cq + r_q2 + eirc_pkg::COLOR_W'(w_cc);
            r_cr   <= w_cnext;
            r_t    <= r_t + NW'(1);
            r_prev <= w_brk;
        end
    end

    // One cell entry leaves each fill cycle.
    always_comb begin
        o_cfg.brk_lo = r_prev;
        o_cfg.brk_hi = w_brk;
        o_cfg.color  = r_cq + eirc_pkg::COLOR_W'(1);
        o_cfg.en     = (r_t <= i_n);
    end

    assign o_shift = (r_state == S_FILL);
    assign o_ready = (r_state == S_READY);

    a_fill_ends_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) && (r_t == T_LAST) && !i_restart |=> o_ready)
        else $error("setup did not become ready after the last break");

endmodule

`default_nettype wire

// File: rtl/core/eirc_cell.sv
`default_nettype none

module eirc_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  wire eirc_pkg::t_cell_cfg i_cfg,
    output eirc_pkg::t_cell_cfg  o_cfg,
    input  wire                  i_adv,
    input  wire eirc_pkg::t_tok  i_tok,
    output eirc_pkg::t_tok       o_tok
);

    eirc_pkg::t_cell_cfg r_cfg;
    eirc_pkg::t_tok      r_tok;
    eirc_pkg::t_tok      n_tok;
    logic                w_hit;

    // Interval entries shift one cell down the row while the breaks load.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_cfg <= i_cfg;
        end
    end

    // The first cell whose interval holds the sample sets its color.
    always_comb begin
        w_hit = r_cfg.en && ($signed(i_tok.sample) >= $signed(r_cfg.brk_lo))
                         && ($signed(i_tok.sample) <  $signed(r_cfg.brk_hi));
        n_tok = i_tok;
        if (!i_tok.found && w_hit) begin
            n_tok.found = 1'b1;
            n_tok.color = r_cfg.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_cfg = r_cfg;
    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/core/equal_interval_raster_classifier_top.sv
`default_nettype none

// Equal-interval raster classifier. Each Q16.16 sample on the slave stream gives one
// 8-bit color index on the master stream: 0 for a no-data value or a value below the
// range, 1 at or just below the minimum, 1..255 for the class colors and 255 at or
// above the maximum. One sample is taken every cycle while the breaks are ready and
// the row is not stalled; each result passes the head stage and then the row of
// MAX_CLASSES classifier cells that every sample walks through, one cell per cycle.
// The whole row stalls only while a result waits on the master side. After reset and
// after every configuration write the breaks are rebuilt: a start state, two passes of
// a bit-serial divider (32 steps each) and the shift of the breaks into the cells,
// during which o_s_tready stays low.
module equal_interval_raster_classifier_top #(
    parameter int MAX_CLASSES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration writes.
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_wdata,
    // Sample stream.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] sample
    // Color stream.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata    // [7:0] color_index
);

    localparam int NW = $clog2(MAX_CLASSES + 1);
    localparam int CW = (NW > eirc_pkg::NCLS_W) ? NW : eirc_pkg::NCLS_W;
    localparam int SW = eirc_pkg::SAMPLE_W;

    logic signed [SW-1:0]          r_data_min;
    logic signed [SW-1:0]          r_data_max;
    logic                          r_zero_center;
    logic [eirc_pkg::NCLS_W-1:0]   r_num_classes;
    logic signed [SW-1:0]          r_nodata_a;
    logic signed [SW-1:0]          r_nodata_b;

    logic [CW-1:0]                 w_nc_ext;
    logic [NW-1:0]                 w_n;
    logic signed [SW-1:0]          w_mag;
    logic signed [SW-1:0]          w_lo;
    logic signed [SW-1:0]          w_hi;

    eirc_pkg::t_cell_cfg           w_setup_cfg;
    logic                          w_shift;
    logic                          w_ready;
    logic                          w_adv;

    eirc_pkg::t_tok                r_head;
    eirc_pkg::t_tok                n_head;
    logic signed [SW-1:0]          w_s;
    logic signed [SW+1:0]          w_lo_m1;
    logic                          w_nodata;
    logic                          w_top;
    logic                          w_band;

    eirc_pkg::t_cell_cfg           w_cfg [MAX_CLASSES];
    eirc_pkg::t_tok                w_tok [MAX_CLASSES+1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_min    <= '0;
            r_data_max    <= SW'(eirc_pkg::ONE_Q16);
            r_zero_center <= 1'b0;
            r_num_classes <= eirc_pkg::NCLS_W'(10);
            r_nodata_a    <= '0;
            r_nodata_b    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eirc_pkg::CFG_DATA_MIN:    r_data_min    <= i_cfg_wdata;
                eirc_pkg::CFG_DATA_MAX:    r_data_max    <= i_cfg_wdata;
                eirc_pkg::CFG_ZERO_CENTER: r_zero_center <= i_cfg_wdata[0];
                eirc_pkg::CFG_NUM_CLASSES: r_num_classes <= i_cfg_wdata[eirc_pkg::NCLS_W-1:0];
                eirc_pkg::CFG_NODATA_A:    r_nodata_a    <= i_cfg_wdata;
                eirc_pkg::CFG_NODATA_B:    r_nodata_b    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Class count clamped to the supported span.
    always_comb begin
        w_nc_ext = CW'(r_num_classes);
        priority if (w_nc_ext < CW'(2)) begin
            w_n = NW'(2);
        end else if (w_nc_ext > CW'(MAX_CLASSES)) begin
            w_n = NW'(MAX_CLASSES);
        end else begin
            w_n = w_nc_ext[NW-1:0];
        end
    end

    // Adjusted range; centering with a negative minimum makes it symmetric.
    always_comb begin
        w_mag = (r_data_min == {1'b1, {(SW-1){1'b0}}}) ? {1'b0, {(SW-1){1'b1}}}
                                                        : -r_data_min;
        w_lo  = r_data_min;
        w_hi  = r_data_max;
        if (r_zero_center && r_data_min[SW-1]) begin
            if (w_mag > r_data_max) begin
                w_hi = w_mag;
            end else begin
                w_lo = -r_data_max;
            end
        end
    end

    eirc_setup #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_lo      (w_lo),
        .i_hi      (w_hi),
        .i_n       (w_n),
        .i_center  (r_zero_center),
        .o_cfg     (w_setup_cfg),
        .o_shift   (w_shift),
        .o_ready   (w_ready)
    );

    // The row moves whenever the last cell is empty or its result is taken.
    assign w_adv      = !w_tok[MAX_CLASSES].valid || i_m_tready;
    assign o_s_tready = w_ready && w_adv;

    // Head stage: no-data, top-of-range and at-or-just-below-minimum cases.
    always_comb begin
        w_s      = i_s_tdata;
        w_lo_m1  = {{2{w_lo[SW-1]}}, w_lo} - (SW+2)'(eirc_pkg::ONE_Q16);
        w_nodata = (w_s == r_nodata_a) || (w_s == r_nodata_b);
        w_top    = (w_s >= w_hi);
        w_band   = (w_s <= w_lo) && ($signed({{2{w_s[SW-1]}}, w_s}) > w_lo_m1);
        n_head.valid  = i_s_tvalid && w_ready;
        n_head.sample = w_s;
        n_head.found  = 1'b1;
        priority if (w_nodata) begin
            n_head.color = eirc_pkg::COLOR_W'(eirc_pkg::COLOR_NONE);
        end else if (w_top) begin
            n_head.color = eirc_pkg::COLOR_W'(eirc_pkg::COLOR_TOP);
        end else if (w_band) begin
            n_head.color = eirc_pkg::COLOR_W'(eirc_pkg::COLOR_LOW);
        end else begin
            n_head.found = 1'b0;
            n_head.color = eirc_pkg::COLOR_W'(eirc_pkg::COLOR_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (w_adv) begin
            r_head <= n_head;
        end
    end

    assign w_tok[0] = r_head;

    // Row of classifier cells; breaks enter at the far end and shift toward cell 0.
    for (genvar j = 0; j < MAX_CLASSES; j++) begin : g_cell
        eirc_pkg::t_cell_cfg w_cfg_in;
        if (j == MAX_CLASSES - 1) begin : g_end
            assign w_cfg_in = w_setup_cfg;
        end else begin : g_mid
            assign w_cfg_in = w_cfg[j+1];
        end
        eirc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_cfg   (w_cfg_in),
            .o_cfg   (w_cfg[j]),
            .i_adv   (w_adv),
            .i_tok   (w_tok[j]),
            .o_tok   (w_tok[j+1])
        );
    end

    assign o_m_tvalid = w_tok[MAX_CLASSES].valid;
    assign o_m_tdata  = w_tok[MAX_CLASSES].color;

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_tready)
        else $error("sample accepted right after a configuration write");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("sample accepted while the cell row is stalled");

    a_accept_enters_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_head.valid)
        else $error("accepted transaction missing from the head stage");

endmodule

`default_nettype wire
